// ----- src/arfm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package arfm_pkg;

    localparam int ENTRY_W     = 6;
    localparam int SEL_W       = 4;
    localparam int WORD_W      = 32;
    localparam int COORD_W     = 24;
    localparam int SCALE_W     = 23;
    localparam int BOUND_W     = 16;
    localparam int ID_W        = 8;
    localparam int CNT_W       = 7;
    localparam int PROD_W      = COORD_W + SCALE_W;
    localparam int SUM_W       = 56;
    localparam int FRAC_SHIFT  = 20;
    localparam int BOUND_SHIFT = 28;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [SEL_W-1:0] {
        WS_X_OFF   = 4'd0,
        WS_X_SX    = 4'd1,
        WS_X_SY    = 4'd2,
        WS_Y_OFF   = 4'd3,
        WS_Y_SX    = 4'd4,
        WS_Y_SY    = 4'd5,
        WS_X_MIN   = 4'd6,
        WS_X_MAX   = 4'd7,
        WS_Y_MIN   = 4'd8,
        WS_Y_MAX   = 4'd9,
        WS_CHIP_ID = 4'd10
    } sel_t;

    // table write broadcast to every cell
    typedef struct packed {
        logic                     we;
        logic [ENTRY_W-1:0]       entry;
        sel_t                     sel;
        logic signed [WORD_W-1:0] value;
    } ld_t;

    // query word walking down the chain
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      found;
        logic [ID_W-1:0]           chip_id;
        logic signed [SUM_W-1:0]   sum_x;
        logic signed [SUM_W-1:0]   sum_y;
    } tok_t;

endpackage

`default_nettype wire

// ----- src/arfm_query_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface arfm_query_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      action;
    logic [arfm_pkg::ENTRY_W-1:0]              entry;
    logic [arfm_pkg::SEL_W-1:0]                word_select;
    logic signed [arfm_pkg::WORD_W-1:0]        word_value;
    logic signed [arfm_pkg::COORD_W-1:0]       point_x;
    logic signed [arfm_pkg::COORD_W-1:0]       point_y;

    modport source (output valid, action, entry, word_select, word_value, point_x, point_y,
                    input ready);
    modport sink (input valid, action, entry, word_select, word_value, point_x, point_y,
                  output ready);
endinterface

`default_nettype wire

// ----- src/arfm_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface arfm_result_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic [arfm_pkg::ID_W-1:0]           chip_id;
    logic signed [arfm_pkg::COORD_W-1:0] chip_x;
    logic signed [arfm_pkg::COORD_W-1:0] chip_y;

    modport source (output valid, found, chip_id, chip_x, chip_y, input ready);
    modport sink (input valid, found, chip_id, chip_x, chip_y, output ready);
endinterface

`default_nettype wire

// ----- src/arfm_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface arfm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [arfm_pkg::CNT_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- src/arfm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module arfm_cell #(
    parameter int CELL_INDEX = 0,
    parameter int BOX_SLACK  = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           active,
    input  arfm_pkg::ld_t  ld,
    input  logic           in_valid,
    input  arfm_pkg::tok_t in_tok,
    output logic           out_valid,
    output arfm_pkg::tok_t out_tok
);
    import arfm_pkg::*;

    logic signed [WORD_W-1:0]  off_x_reg, off_y_reg;
    logic signed [SCALE_W-1:0] s_xx_reg, s_xy_reg, s_yx_reg, s_yy_reg;
    logic signed [BOUND_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [ID_W-1:0]           id_reg;

    logic                      s1_valid_reg;
    tok_t                      s1_tok_reg;
    logic signed [PROD_W-1:0]  p_xx_reg, p_xy_reg, p_yx_reg, p_yy_reg;
    logic signed [PROD_W-1:0]  p_xx_next, p_xy_next, p_yx_next, p_yy_next;

    logic                      out_valid_reg;
    tok_t                      out_tok_reg;
    tok_t                      tok_next;

    logic                      wr_en;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic signed [SUM_W-1:0]   lo_x, hi_x, lo_y, hi_y;
    logic                      in_box;

    assign wr_en = ld.we && (32'(ld.entry) == CELL_INDEX);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            unique case (ld.sel)
                WS_X_OFF:   off_x_reg <= ld.value;
                WS_X_SX:    s_xx_reg  <= ld.value[SCALE_W-1:0];
                WS_X_SY:    s_xy_reg  <= ld.value[SCALE_W-1:0];
                WS_Y_OFF:   off_y_reg <= ld.value;
                WS_Y_SX:    s_yx_reg  <= ld.value[SCALE_W-1:0];
                WS_Y_SY:    s_yy_reg  <= ld.value[SCALE_W-1:0];
                WS_X_MIN:   x_min_reg <= ld.value[BOUND_W-1:0];
                WS_X_MAX:   x_max_reg <= ld.value[BOUND_W-1:0];
                WS_Y_MIN:   y_min_reg <= ld.value[BOUND_W-1:0];
                WS_Y_MAX:   y_max_reg <= ld.value[BOUND_W-1:0];
                WS_CHIP_ID: id_reg    <= ld.value[ID_W-1:0];
                default:    ;
            endcase
        end
    end

    // stage 1: the four products
    assign p_xx_next = in_tok.point_x * s_xx_reg;
    assign p_xy_next = in_tok.point_y * s_xy_reg;
    assign p_yx_next = in_tok.point_x * s_yx_reg;
    assign p_yy_next = in_tok.point_y * s_yy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_tok_reg <= in_tok;
            p_xx_reg   <= p_xx_next;
            p_xy_reg   <= p_xy_next;
            p_yx_reg   <= p_yx_next;
            p_yy_reg   <= p_yy_next;
        end
    end

    // stage 2: sums at Q.28 against the widened box
    always_comb
    begin
        sum_x = (SUM_W'(off_x_reg) <<< FRAC_SHIFT) + SUM_W'(p_xx_reg) + SUM_W'(p_xy_reg);
        sum_y = (SUM_W'(off_y_reg) <<< FRAC_SHIFT) + SUM_W'(p_yx_reg) + SUM_W'(p_yy_reg);
        lo_x  = (SUM_W'(x_min_reg) - SUM_W'(BOX_SLACK)) <<< BOUND_SHIFT;
        hi_x  = (SUM_W'(x_max_reg) + SUM_W'(BOX_SLACK)) <<< BOUND_SHIFT;
        lo_y  = (SUM_W'(y_min_reg) - SUM_W'(BOX_SLACK)) <<< BOUND_SHIFT;
        hi_y  = (SUM_W'(y_max_reg) + SUM_W'(BOX_SLACK)) <<< BOUND_SHIFT;
        in_box = (sum_x >= lo_x) && (sum_x <= hi_x) && (sum_y >= lo_y) && (sum_y <= hi_y);
        tok_next = s1_tok_reg;
        // keep the first hit from an earlier cell
        if (!s1_tok_reg.found && active && in_box)
        begin
            tok_next.found   = 1'b1;
            tok_next.chip_id = id_reg;
            tok_next.sum_x   = sum_x;
            tok_next.sum_y   = sum_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            out_tok_reg <= tok_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

endmodule

`default_nettype wire

// ----- src/arfm_outbuf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module arfm_outbuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           done_valid,
    input  arfm_pkg::tok_t done_tok,
    output logic           pend_busy,
    arfm_result_if.source  result
);
    import arfm_pkg::*;

    typedef struct packed {
        logic                      found;
        logic [ID_W-1:0]           chip_id;
        logic signed [COORD_W-1:0] chip_x;
        logic signed [COORD_W-1:0] chip_y;
    } res_t;

    localparam logic signed [SUM_W:0] ROUND_HALF = (SUM_W+1)'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [SUM_W:0] SAT_HI = (SUM_W+1)'((1 <<< (COORD_W - 1)) - 1);
    localparam logic signed [SUM_W:0] SAT_LO = -((SUM_W+1)'(1) <<< (COORD_W - 1));

    // Q.28 to Q.8, round half up, saturate
    function automatic logic signed [COORD_W-1:0] to_coord(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W:0] t;
        logic signed [SUM_W:0] q;
        logic signed [COORD_W-1:0] r;
        t = (SUM_W+1)'(v) + ROUND_HALF;
        q = t >>> FRAC_SHIFT;
        if (q > SAT_HI)
        begin
            r = SAT_HI[COORD_W-1:0];
        end
        else if (q < SAT_LO)
        begin
            r = SAT_LO[COORD_W-1:0];
        end
        else
        begin
            r = q[COORD_W-1:0];
        end
        return r;
    endfunction

    logic out_valid_reg, out_valid_next;
    logic pend_valid_reg, pend_valid_next;
    res_t out_res_reg, pend_res_reg;
    res_t done_res;
    logic take, load_out, load_pend, out_from_pend;

    always_comb
    begin
        done_res = '0;
        if (done_tok.found)
        begin
            done_res.found   = 1'b1;
            done_res.chip_id = done_tok.chip_id;
            done_res.chip_x  = to_coord(done_tok.sum_x);
            done_res.chip_y  = to_coord(done_tok.sum_y);
        end
    end

    assign take = out_valid_reg && result.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        load_out        = 1'b0;
        load_pend       = 1'b0;
        out_from_pend   = 1'b0;
        if (!out_valid_reg || take)
        begin
            if (pend_valid_reg)
            begin
                load_out        = 1'b1;
                out_from_pend   = 1'b1;
                out_valid_next  = 1'b1;
                pend_valid_next = done_valid;
                load_pend       = done_valid;
            end
            else
            begin
                out_valid_next = done_valid;
                load_out       = done_valid;
            end
        end
        else if (done_valid)
        begin
            // output held: park the word
            pend_valid_next = 1'b1;
            load_pend       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_res_reg <= out_from_pend ? pend_res_reg : done_res;
        end
        if (load_pend)
        begin
            pend_res_reg <= done_res;
        end
    end

    assign pend_busy      = pend_valid_reg;
    assign result.valid   = out_valid_reg;
    assign result.found   = out_res_reg.found;
    assign result.chip_id = out_res_reg.chip_id;
    assign result.chip_x  = out_res_reg.chip_x;
    assign result.chip_y  = out_res_reg.chip_y;

endmodule

`default_nettype wire

// ----- src/affine_region_first_match_top.sv -----
// Channel  Dir  Handshake      Word
// query    in   valid/ready    action, entry, word_select, word_value, point_x, point_y
// result   out  valid/ready    found, chip_id, chip_x, chip_y
// cfg      in   valid/ready    data = entries_in_use
//
// A query walks the cell chain; each cell registers the products, then the sum and
// box test, and the last cell hands the word to the result register. The chain holds one
// query at a time, so no further word is taken while a query is in the chain.
// rst_n clears the control state and entries_in_use; table words are undefined
// until loaded. One finished result may wait in a spare register while the
// output stalls; the next query or load is taken once the chain and spare are free.
`timescale 1ns / 1ps
`default_nettype none

module affine_region_first_match_top #(
    parameter int MAX_CHIPS = 64,
    parameter int BOX_SLACK = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    arfm_query_if.sink   query,
    arfm_result_if.source result,
    arfm_cfg_if.sink     cfg
);
    import arfm_pkg::*;

    logic [CNT_W-1:0]   entries_reg;
    logic               chain_busy_reg, chain_busy_next;
    logic               pend_busy;
    logic               q_acc, q_query;
    ld_t                ld;
    tok_t               head_tok;
    logic [MAX_CHIPS:0] chain_valid;
    tok_t               chain_tok [0:MAX_CHIPS];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= '0;
        end
        else if (cfg.valid)
        begin
            entries_reg <= cfg.data;
        end
    end

    assign query.ready = !chain_busy_reg && !pend_busy;
    assign q_acc       = query.valid && query.ready;
    assign q_query     = q_acc && (query.action == ACT_QUERY);

    always_comb
    begin
        ld.we    = q_acc && (query.action == ACT_LOAD);
        ld.entry = query.entry;
        ld.sel   = sel_t'(query.word_select);
        ld.value = query.word_value;
    end

    always_comb
    begin
        head_tok.point_x = query.point_x;
        head_tok.point_y = query.point_y;
        head_tok.found   = 1'b0;
        head_tok.chip_id = '0;
        head_tok.sum_x   = '0;
        head_tok.sum_y   = '0;
    end

    assign chain_valid[0] = q_query;
    assign chain_tok[0]   = head_tok;

    generate
        for (genvar i = 0; i < MAX_CHIPS; i++)
        begin : g_cell
            arfm_cell #(
                .CELL_INDEX (i),
                .BOX_SLACK  (BOX_SLACK)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .active    (32'(entries_reg) > i),
                .ld        (ld),
                .in_valid  (chain_valid[i]),
                .in_tok    (chain_tok[i]),
                .out_valid (chain_valid[i+1]),
                .out_tok   (chain_tok[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        chain_busy_next = chain_busy_reg;
        if (q_query)
        begin
            chain_busy_next = 1'b1;
        end
        else if (chain_valid[MAX_CHIPS])
        begin
            chain_busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_busy_reg <= 1'b0;
        end
        else
        begin
            chain_busy_reg <= chain_busy_next;
        end
    end

    arfm_outbuf u_outbuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .done_valid (chain_valid[MAX_CHIPS]),
        .done_tok   (chain_tok[MAX_CHIPS]),
        .pend_busy  (pend_busy),
        .result     (result)
    );

`ifndef ASSERT_OFF
    a_one_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(chain_valid) <= 1)
        else $error("more than one query word in the cell chain");

    a_exit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[MAX_CHIPS] |-> chain_busy_reg)
        else $error("query word left the chain with no query in flight");

    a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        q_query |=> chain_busy_reg)
        else $error("chain not marked busy after a query");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.found |->
            result.chip_id == '0 && result.chip_x == '0 && result.chip_y == '0)
        else $error("miss result carries nonzero fields");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_affine_region_first_match_top.sv -----
`timescale 1ns / 1ps

module tb_affine_region_first_match_top;
    import arfm_pkg::*;

    localparam int MAX_CHIPS    = 64;
    localparam int BOX_SLACK    = 2;
    localparam int NUM_WORDS    = 11;
    localparam int CHAIN_CYCLES = 2 * MAX_CHIPS + 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_PCT     = 21;

    localparam longint OFF_UNIT   = 64'sd1 <<< FRAC_SHIFT;
    localparam longint BOUND_UNIT = 64'sd1 <<< BOUND_SHIFT;
    localparam longint COORD_HI   = (64'sd1 <<< (COORD_W - 1)) - 1;
    localparam longint COORD_LO   = -(64'sd1 <<< (COORD_W - 1));

    typedef struct {
        logic                      found;
        logic [ID_W-1:0]           chip_id;
        logic signed [COORD_W-1:0] chip_x;
        logic signed [COORD_W-1:0] chip_y;
    } chip_hit_t;

    logic clk;
    logic rst_n;

    arfm_query_if  query_bus();
    arfm_result_if result_bus();
    arfm_cfg_if    cfg_bus();

    affine_region_first_match_top #(
        .MAX_CHIPS(MAX_CHIPS),
        .BOX_SLACK(BOX_SLACK)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .query(query_bus),
        .result(result_bus),
        .cfg(cfg_bus)
    );

    // chip table as the block should hold it
    longint           x_off [MAX_CHIPS];
    longint           y_off [MAX_CHIPS];
    longint           x_sx [MAX_CHIPS];
    longint           x_sy [MAX_CHIPS];
    longint           y_sx [MAX_CHIPS];
    longint           y_sy [MAX_CHIPS];
    longint           x_lo [MAX_CHIPS];
    longint           x_hi [MAX_CHIPS];
    longint           y_lo [MAX_CHIPS];
    longint           y_hi [MAX_CHIPS];
    logic [ID_W-1:0]  chip_tag [MAX_CHIPS];
    logic [NUM_WORDS-1:0] words_loaded [MAX_CHIPS];
    logic [CNT_W-1:0] entries_searched;

    chip_hit_t expected_hits[$];
    chip_hit_t oldest_hit;
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        steady_flow = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_affine_region_first_match_top NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic longint clamp_coord(longint v);
        return (v > COORD_HI) ? COORD_HI : ((v < COORD_LO) ? COORD_LO : v);
    endfunction

    // Q.28 down to Q.8, ties toward plus infinity, then saturate
    function automatic logic signed [COORD_W-1:0] round_coord(longint v);
        longint q;
        q = clamp_coord((v + (OFF_UNIT >>> 1)) >>> FRAC_SHIFT);
        return q[COORD_W-1:0];
    endfunction

    function automatic bit in_band(longint v, longint lo, longint hi);
        return v >= (lo - BOX_SLACK) * BOUND_UNIT && v <= (hi + BOX_SLACK) * BOUND_UNIT;
    endfunction

    function automatic chip_hit_t predict_chip_lookup(logic signed [COORD_W-1:0] px,
                                                      logic signed [COORD_W-1:0] py);
        chip_hit_t hit;
        longint    lx;
        longint    ly;
        longint    mx;
        longint    my;
        int        lim;
        hit = '{found: 1'b0, chip_id: '0, chip_x: '0, chip_y: '0};
        lx = px;
        ly = py;
        lim = (entries_searched > MAX_CHIPS) ? MAX_CHIPS : int'(entries_searched);
        for (int i = 0; i < lim; i++)
        begin
            mx = x_off[i] * OFF_UNIT + x_sx[i] * lx + x_sy[i] * ly;
            my = y_off[i] * OFF_UNIT + y_sx[i] * lx + y_sy[i] * ly;
            if (in_band(mx, x_lo[i], x_hi[i]) && in_band(my, y_lo[i], y_hi[i]))
            begin
                hit.found   = 1'b1;
                hit.chip_id = chip_tag[i];
                hit.chip_x  = round_coord(mx);
                hit.chip_y  = round_coord(my);
                return hit;
            end
        end
        return hit;
    endfunction

    function automatic void store_word(logic [ENTRY_W-1:0] e, logic [SEL_W-1:0] sel,
                                       logic [WORD_W-1:0] val);
        if (e >= MAX_CHIPS)
            return;
        case (sel)
            WS_X_OFF:   x_off[e] = longint'($signed(val));
            WS_Y_OFF:   y_off[e] = longint'($signed(val));
            WS_X_SX:    x_sx[e] = longint'($signed(val[SCALE_W-1:0]));
            WS_X_SY:    x_sy[e] = longint'($signed(val[SCALE_W-1:0]));
            WS_Y_SX:    y_sx[e] = longint'($signed(val[SCALE_W-1:0]));
            WS_Y_SY:    y_sy[e] = longint'($signed(val[SCALE_W-1:0]));
            WS_X_MIN:   x_lo[e] = longint'($signed(val[BOUND_W-1:0]));
            WS_X_MAX:   x_hi[e] = longint'($signed(val[BOUND_W-1:0]));
            WS_Y_MIN:   y_lo[e] = longint'($signed(val[BOUND_W-1:0]));
            WS_Y_MAX:   y_hi[e] = longint'($signed(val[BOUND_W-1:0]));
            WS_CHIP_ID: chip_tag[e] = val[ID_W-1:0];
            default:    return;
        endcase
        words_loaded[e][sel] = 1'b1;
    endfunction

    function automatic void report_field(string field, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual found=%0b id=%0d x=%0d y=%0d",
                         $time, result_bus.found, result_bus.chip_id, result_bus.chip_x,
                         result_bus.chip_y);
                mismatch_count++;
            end
            else
            begin
                oldest_hit = expected_hits.pop_front();
                report_field("found", oldest_hit.found, result_bus.found);
                report_field("chip_id", oldest_hit.chip_id, result_bus.chip_id);
                report_field("chip_x", oldest_hit.chip_x, result_bus.chip_x);
                report_field("chip_y", oldest_hit.chip_y, result_bus.chip_y);
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        logic [31:0] r;
        r = $urandom();
        return r[COORD_W-1:0];
    endfunction

    // sane table word; upper bits beyond the kept width stay random
    function automatic logic [WORD_W-1:0] plausible_word(logic [SEL_W-1:0] sel);
        logic [WORD_W-1:0] w;
        int                v;
        w = $urandom();
        case (sel)
            WS_X_OFF, WS_Y_OFF:
                w = $urandom_range(6000 * 256) - 3000 * 256;
            WS_X_SX, WS_Y_SY:
            begin
                case ($urandom_range(5))
                    0:       v = 1 << 20;
                    1:       v = -(1 << 20);
                    2:       v = 1 << 19;
                    3:       v = 3 << 19;
                    4:       v = (1 << 22) - 1;
                    default: v = (1 << 20) + $urandom_range(8192) - 4096;
                endcase
                w[SCALE_W-1:0] = v[SCALE_W-1:0];
            end
            WS_X_SY, WS_Y_SX:
            begin
                v = $urandom_range(8192) - 4096;
                w[SCALE_W-1:0] = v[SCALE_W-1:0];
            end
            WS_X_MIN, WS_Y_MIN:
            begin
                v = $urandom_range(2200) - 1200;
                w[BOUND_W-1:0] = v[BOUND_W-1:0];
            end
            WS_X_MAX, WS_Y_MAX:
            begin
                v = $urandom_range(2200) - 1000;
                w[BOUND_W-1:0] = v[BOUND_W-1:0];
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_word(logic act, logic [ENTRY_W-1:0] e, logic [SEL_W-1:0] sel,
                             logic [WORD_W-1:0] val, logic signed [COORD_W-1:0] px,
                             logic signed [COORD_W-1:0] py);
        int gap;
        gap = 0;
        if (!steady_flow)
        begin
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
            // now and then land the next word late in the chain walk
            if ($urandom_range(99) < 5)
                gap += $urandom_range(CHAIN_CYCLES);
        end
        if (gap > 0)
        begin
            query_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query_bus.valid       <= 1'b1;
        query_bus.action      <= act;
        query_bus.entry       <= e;
        query_bus.word_select <= sel;
        query_bus.word_value  <= val;
        query_bus.point_x     <= px;
        query_bus.point_y     <= py;
        do @(posedge clk); while (!query_bus.ready);
        if (act == ACT_QUERY)
            expected_hits.push_back(predict_chip_lookup(px, py));
        else
            store_word(e, sel, val);
    endtask

    task automatic hold_for_results();
        query_bus.valid <= 1'b0;
        do @(posedge clk); while (expected_hits.size() != 0);
    endtask

    task automatic wait_idle();
        hold_for_results();
        repeat (CHAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_entries(logic [CNT_W-1:0] n);
        wait_idle();
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= n;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        entries_searched = n;
    endtask

    task automatic load_chip(int e);
        logic [WORD_W-1:0] w;
        int                lo;
        for (int s = 0; s < NUM_WORDS; s++)
        begin
            w = plausible_word(SEL_W'(s));
            // keep each box mostly upright
            if (s == WS_X_MAX || s == WS_Y_MAX)
            begin
                lo = int'((s == WS_X_MAX) ? x_lo[e] : y_lo[e]) + $urandom_range(800) - 10;
                w[BOUND_W-1:0] = lo[BOUND_W-1:0];
            end
            send_word(ACT_LOAD, ENTRY_W'(e), SEL_W'(s), w, rand_coord(), rand_coord());
        end
    endtask

    function automatic longint pick_target(longint lo, longint hi);
        longint span;
        longint base;
        if (hi < lo)
            hi = lo;
        span = hi - lo + 2 * BOX_SLACK + 3;
        base = lo - BOX_SLACK - 1 + longint'($urandom_range(span - 1));
        return base * BOUND_UNIT + longint'($urandom_range(BOUND_UNIT - 1));
    endfunction

    // solve the entry's map backward so the point lands in or near its box
    task automatic query_toward(int e);
        longint tx;
        longint ty;
        longint vx;
        longint vy;
        if (x_sx[e] == 0 || y_sy[e] == 0)
        begin
            send_word(ACT_QUERY, ENTRY_W'($urandom), SEL_W'($urandom), $urandom,
                      rand_coord(), rand_coord());
            return;
        end
        tx = pick_target(x_lo[e], x_hi[e]);
        ty = pick_target(y_lo[e], y_hi[e]);
        vy = longint'($urandom_range(1 << 21)) - (1 << 20);
        vx = 0;
        repeat (2)
        begin
            vx = clamp_coord((tx - x_off[e] * OFF_UNIT - x_sy[e] * vy) / x_sx[e]);
            vy = clamp_coord((ty - y_off[e] * OFF_UNIT - y_sx[e] * vx) / y_sy[e]);
        end
        vx = clamp_coord((tx - x_off[e] * OFF_UNIT - x_sy[e] * vy) / x_sx[e]);
        send_word(ACT_QUERY, ENTRY_W'($urandom), SEL_W'($urandom), $urandom,
                  vx[COORD_W-1:0], vy[COORD_W-1:0]);
    endtask

    task automatic run_mixed(logic [CNT_W-1:0] n, int items);
        int               lim;
        int               r;
        int               e;
        logic [SEL_W-1:0] sel;
        set_entries(n);
        lim = (n > MAX_CHIPS) ? MAX_CHIPS : int'(n);
        // never let a query read an entry that was not fully loaded
        for (int i = 0; i < lim; i++)
            if (!(&words_loaded[i]))
                load_chip(i);
        for (int k = 0; k < items; k++)
        begin
            r = $urandom_range(99);
            if (r < 55 && lim > 0)
                query_toward($urandom_range(lim - 1));
            else if (r < 65)
                send_word(ACT_QUERY, ENTRY_W'($urandom), SEL_W'($urandom), $urandom,
                          rand_coord(), rand_coord());
            else if (r < 82)
            begin
                sel = SEL_W'($urandom_range(int'(WS_CHIP_ID)));
                send_word(ACT_LOAD, ENTRY_W'($urandom_range(MAX_CHIPS - 1)), sel,
                          plausible_word(sel), rand_coord(), rand_coord());
            end
            else if (r < 86)
            begin
                e = (lim > 0) ? $urandom_range(lim - 1) : $urandom_range(MAX_CHIPS - 1);
                load_chip(e);
            end
            else if (r < 97)
                send_word(ACT_LOAD, ENTRY_W'($urandom), SEL_W'($urandom), $urandom,
                          rand_coord(), rand_coord());
            else
                hold_for_results();
        end
    endtask

    task automatic test_directed_cases();
        int plan [2][NUM_WORDS] = '{
            '{0, 1 << 20, 0, 0, 0, 3 << 19, -100, 100, -100, 100, 8'hA5},
            '{16384 * 256, 1 << 20, 0, -16384 * 256, 0, 1 << 20,
              32767, 32767, -32768, -32768, 8'hFF}
        };
        // empty search: everything misses
        set_entries('0);
        send_word(ACT_QUERY, '0, '0, '0, 24'sh7FFFFF, 24'sh800000);
        send_word(ACT_QUERY, '0, '0, '0, 24'sh800000, 24'sh7FFFFF);
        for (int e = 0; e < 2; e++)
            for (int s = 0; s < NUM_WORDS; s++)
                send_word(ACT_LOAD, ENTRY_W'(e), SEL_W'(s), plan[e][s], '0, '0);
        set_entries(CNT_W'(2));
        // slack edges of entry 0 inclusive, one Q.8 step past them misses;
        // y scale of 1.5 on odd y lands on a rounding tie
        send_word(ACT_QUERY, '0, '0, '0, COORD_W'(-102 * 256), COORD_W'(1));
        send_word(ACT_QUERY, '0, '0, '0, COORD_W'(-102 * 256 - 1), COORD_W'(1));
        send_word(ACT_QUERY, '0, '0, '0, COORD_W'(102 * 256), COORD_W'(-1));
        send_word(ACT_QUERY, '0, '0, '0, COORD_W'(102 * 256 + 1), COORD_W'(-1));
        // entry 1 maps past both ends of the output range
        send_word(ACT_QUERY, '0, '0, '0, COORD_W'(16384 * 256 + 128),
                  COORD_W'(-(16384 * 256 + 128)));
        send_word(ACT_QUERY, '0, '0, '0, 24'sh7FFFFF, 24'sh800000);
        // selects past the chip id must leave the table alone
        for (int s = NUM_WORDS; s < 16; s++)
            send_word(ACT_LOAD, '0, SEL_W'(s), $urandom, '0, '0);
        send_word(ACT_QUERY, '0, '0, '0, COORD_W'(-102 * 256), COORD_W'(1));
    endtask

    task automatic test_single_entry();
        run_mixed(CNT_W'(1), 110);
    endtask

    task automatic test_full_table();
        run_mixed(CNT_W'(MAX_CHIPS), 170);
    endtask

    task automatic test_oversized_count();
        steady_flow = 1'b1;
        run_mixed(7'd127, 160);
        steady_flow = 1'b0;
        run_mixed(CNT_W'(MAX_CHIPS + 1), 90);
    endtask

    task automatic test_partial_table();
        run_mixed(CNT_W'($urandom_range(2, MAX_CHIPS - 1)), 130);
        run_mixed('0, 30);
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        query_bus.valid       = 1'b0;
        query_bus.action      = ACT_LOAD;
        query_bus.entry       = '0;
        query_bus.word_select = '0;
        query_bus.word_value  = '0;
        query_bus.point_x     = '0;
        query_bus.point_y     = '0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.data          = '0;
        result_bus.ready      = 1'b0;
        entries_searched      = '0;
        for (int i = 0; i < MAX_CHIPS; i++)
            words_loaded[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_single_entry();
        test_full_table();
        test_oversized_count();
        test_partial_table();

        wait_idle();
        if (mismatch_count == 0)
            $display("tb_affine_region_first_match_top OK");
        else
            $display("tb_affine_region_first_match_top NOT OK");
        $finish;
    end

endmodule
